>>> hw/rtl/tls_record_state_extractor_macros.svh
// Assertion macros shared by the record state extractor RTL.
`ifndef TLS_RECORD_STATE_EXTRACTOR_MACROS_SVH
`define TLS_RECORD_STATE_EXTRACTOR_MACROS_SVH

// Checked only while the block is out of reset.
`define TLSRSE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TLSRSE_ASSERT_ALW(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/tlsrse_pkg.sv
// Types and constants for the TLS record state extractor.
`default_nettype none

package tlsrse_pkg;

  localparam logic [7:0] AppDataType  = 8'h17;
  localparam logic [7:0] AppDataCode  = 8'hFF;
  localparam logic [2:0] EmitPosition = 3'd6;
  localparam logic [2:0] PosType      = 3'd0;
  localparam logic [2:0] PosLenHigh   = 3'd3;
  localparam logic [2:0] PosLenLow    = 3'd4;
  localparam logic [2:0] PosMsgType   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [15:0] state_code;
    logic [15:0] record_number;
  } out_word_t;

  typedef struct packed {
    logic      emit;
    out_word_t word;
  } parse_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/tls_record_state_extractor.sv
// Top level of the TLS record state extractor.
//
// Bytes of a response buffer enter on the input channel, one word per cycle while
// in_stall_o is low, with end_of_buffer set on the last byte of each buffer. A word
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// For each TLS record the block emits one word on the output channel on the
// record's seventh byte: the state code and the running record number.
// A word leaves at an edge where out_valid_o is high and out_stall_i is low.
// Every accepted byte passes an input register and then the parser; when
// the parser emits for a seventh byte, its word is loaded into the result
// register, which presents it on the output channel.
// One byte is taken every cycle while the output flows.
// When the receiver stalls, the result register holds its word and one more
// byte can wait in the input register before in_stall_o rises.
// Reset clears the parser position, the skip and discard state, and the
// record count; both registers come out of reset empty.
`default_nettype none

`include "tls_record_state_extractor_macros.svh"

module tls_record_state_extractor (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  tlsrse_pkg::in_word_t  in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output tlsrse_pkg::out_word_t out_word_o
);

  logic                   in_valid_q, in_valid_d;
  tlsrse_pkg::in_word_t   in_word_q;
  logic                   out_free;
  logic                   fire;
  logic                   in_take;
  tlsrse_pkg::parse_res_t res;

  assign out_free   = !(out_valid_o && out_stall_i);
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  tlsrse_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (in_word_q),
    .res_o  (res)
  );

  tlsrse_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && res.emit),
    .free_i      (out_free),
    .word_i      (res.word),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  `TLSRSE_ASSERT_RST(a_stall_held, in_stall_o |-> in_valid_q, "stall with empty input register")
  `TLSRSE_ASSERT_RST(a_emit_fire, res.emit |-> fire, "result without a processed byte")
  `TLSRSE_ASSERT_RST(a_out_after_emit, $rose(out_valid_o) |-> $past(res.emit), "output without a result")

endmodule

`default_nettype wire

>>> hw/rtl/tlsrse_parser.sv
// Record header parser state and per-byte update logic.
`default_nettype none

`include "tls_record_state_extractor_macros.svh"

module tlsrse_parser (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   fire_i,
  input  tlsrse_pkg::in_word_t  word_i,
  output tlsrse_pkg::parse_res_t res_o
);

  logic [2:0]  header_position_q, header_position_d;
  logic [7:0]  record_type_q, record_type_d;
  logic [15:0] record_length_q, record_length_d;
  logic [7:0]  handshake_type_q, handshake_type_d;
  logic [15:0] bytes_left_to_skip_q, bytes_left_to_skip_d;
  logic        discard_rest_q, discard_rest_d;
  logic [15:0] records_seen_q, records_seen_d;
  logic        emit;
  logic [7:0]  msg_type;

  always_comb begin
    header_position_d    = header_position_q;
    record_type_d        = record_type_q;
    record_length_d      = record_length_q;
    handshake_type_d     = handshake_type_q;
    bytes_left_to_skip_d = bytes_left_to_skip_q;
    discard_rest_d       = discard_rest_q;
    records_seen_d       = records_seen_q;
    emit                 = 1'b0;
    msg_type = (record_type_q != tlsrse_pkg::AppDataType) ? handshake_type_q
                                                           : tlsrse_pkg::AppDataCode;
    if (fire_i) begin
      priority if (discard_rest_q) begin
        discard_rest_d = 1'b1;
      end else if (bytes_left_to_skip_q != 16'd0) begin
        bytes_left_to_skip_d = bytes_left_to_skip_q - 16'd1;
      end else if (header_position_q < tlsrse_pkg::EmitPosition) begin
        unique case (header_position_q)
          tlsrse_pkg::PosType:    record_type_d = word_i.data_byte;
          tlsrse_pkg::PosLenHigh: record_length_d[15:8] = word_i.data_byte;
          tlsrse_pkg::PosLenLow:  record_length_d[7:0] = word_i.data_byte;
          tlsrse_pkg::PosMsgType: handshake_type_d = word_i.data_byte;
          default: ;
        endcase
        header_position_d = header_position_q + 3'd1;
      end else begin
        emit = 1'b1;
        if (records_seen_q != 16'hFFFF) begin
          records_seen_d = records_seen_q + 16'd1;
        end
        priority if (record_length_q == 16'd0) begin
          header_position_d = 3'd0;
          discard_rest_d    = 1'b1;
        end else if (record_length_q == 16'd1) begin
          header_position_d = 3'd1;
          record_type_d     = word_i.data_byte;
          record_length_d   = 16'd0;
          handshake_type_d  = 8'd0;
        end else begin
          bytes_left_to_skip_d = record_length_q - 16'd2;
          header_position_d    = 3'd0;
        end
      end
      if (word_i.end_of_buffer) begin
        header_position_d    = 3'd0;
        record_type_d        = 8'd0;
        record_length_d      = 16'd0;
        handshake_type_d     = 8'd0;
        bytes_left_to_skip_d = 16'd0;
        discard_rest_d       = 1'b0;
      end
    end
  end

  always_comb begin
    res_o.emit               = emit;
    res_o.word.state_code    = {record_type_q, msg_type};
    res_o.word.record_number = records_seen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_position_q    <= 3'd0;
      record_type_q        <= 8'd0;
      record_length_q      <= 16'd0;
      handshake_type_q     <= 8'd0;
      bytes_left_to_skip_q <= 16'd0;
      discard_rest_q       <= 1'b0;
      records_seen_q       <= 16'd0;
    end else begin
      header_position_q    <= header_position_d;
      record_type_q        <= record_type_d;
      record_length_q      <= record_length_d;
      handshake_type_q     <= handshake_type_d;
      bytes_left_to_skip_q <= bytes_left_to_skip_d;
      discard_rest_q       <= discard_rest_d;
      records_seen_q       <= records_seen_d;
    end
  end

  `TLSRSE_ASSERT_ALW(a_pos_range, header_position_q <= tlsrse_pkg::EmitPosition, "position out of range")
  `TLSRSE_ASSERT_RST(a_discard_pos, discard_rest_q |-> header_position_q == 3'd0, "discard mid-header")
  `TLSRSE_ASSERT_RST(a_skip_pos, bytes_left_to_skip_q != 16'd0 |-> header_position_q == 3'd0, "skip mid-header")
  `TLSRSE_ASSERT_RST(a_count_mono, !fire_i |=> $stable(records_seen_q), "count moved without a word")

endmodule

`default_nettype wire

>>> hw/rtl/tlsrse_out_reg.sv
// Result register on the output channel.
`default_nettype none

`include "tls_record_state_extractor_macros.svh"

module tlsrse_out_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire                    free_i,
  input  tlsrse_pkg::out_word_t  word_i,
  output logic                   out_valid_o,
  output tlsrse_pkg::out_word_t  out_word_o
);

  logic                  valid_q, valid_d;
  tlsrse_pkg::out_word_t word_q;

  always_comb begin
    valid_d = valid_q;
    if (free_i) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_i && load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  `TLSRSE_ASSERT_RST(a_load_free, load_i |-> free_i, "result loaded while register busy")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the TLS record state extractor: byte streams with a model of the record parser.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [7:0]  ChangeCipherType = 8'h14;
  localparam logic [7:0]  AlertType        = 8'h15;
  localparam logic [7:0]  HandshakeType    = 8'h16;
  localparam logic [15:0] CountMax         = 16'hFFFF;
  localparam int          RandomWords      = 650;
  localparam int          LongHold         = 150;
  localparam int          DrainCycles      = 8;
  localparam int          CycleLimit       = 400000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  tlsrse_pkg::in_word_t  in_word_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  tlsrse_pkg::out_word_t out_word_o;

  // Parser state as the testbench tracks it.
  logic [2:0]  hdr_pos;
  logic [7:0]  rec_type;
  logic [15:0] rec_len;
  logic [7:0]  msg_type;
  logic [15:0] skip_left;
  logic        discard_on;
  logic [15:0] rec_count;

  tlsrse_pkg::out_word_t record_codes_q[$];
  tlsrse_pkg::out_word_t want_word;
  logic [7:0] buffer_q[$];
  int         words_sent;
  int         errors;
  int         cycles;
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         long_hold_req;
  int         rx_hold;
  int         rx_run;
  bit         rx_stalled;

  tls_record_state_extractor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic clear_parser();
    hdr_pos = '0;
    rec_type = '0;
    rec_len = '0;
    msg_type = '0;
    skip_left = '0;
    discard_on = 1'b0;
  endtask

  task automatic track_record_byte(input tlsrse_pkg::in_word_t w);
    tlsrse_pkg::out_word_t r;
    if (discard_on) begin
    end else if (skip_left != 0) begin
      skip_left = skip_left - 1;
    end else if (hdr_pos < tlsrse_pkg::EmitPosition) begin
      case (hdr_pos)
        tlsrse_pkg::PosType:    rec_type = w.data_byte;
        tlsrse_pkg::PosLenHigh: rec_len[15:8] = w.data_byte;
        tlsrse_pkg::PosLenLow:  rec_len[7:0] = w.data_byte;
        tlsrse_pkg::PosMsgType: msg_type = w.data_byte;
        default: ;
      endcase
      hdr_pos = hdr_pos + 1;
    end else begin
      if (rec_count != CountMax) rec_count = rec_count + 1;
      r.state_code = {rec_type, (rec_type == tlsrse_pkg::AppDataType) ?
                                tlsrse_pkg::AppDataCode : msg_type};
      r.record_number = rec_count;
      record_codes_q.push_back(r);
      if (rec_len == 16'd0) begin
        hdr_pos = '0;
        discard_on = 1'b1;
      end else if (rec_len == 16'd1) begin
        hdr_pos = 3'd1;
        rec_type = w.data_byte;
        rec_len = '0;
        msg_type = '0;
      end else begin
        skip_left = rec_len - 16'd2;
        hdr_pos = '0;
      end
    end
    if (w.end_of_buffer) clear_parser();
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int tx_gap();
    if (!tx_idle_on || $urandom_range(0, 99) < 60) return 0;
    return idle_len();
  endfunction

  task automatic send_word(input logic [7:0] data, input logic last);
    tlsrse_pkg::in_word_t w;
    int                   gap;
    w.data_byte = data;
    w.end_of_buffer = last;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_record_byte(w);
    words_sent++;
    gap = tx_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic add_record(input logic [7:0] ctype, input logic [15:0] len,
                            input logic [7:0] msg, input int payload);
    buffer_q.push_back(ctype);
    buffer_q.push_back(8'($urandom));
    buffer_q.push_back(8'($urandom));
    buffer_q.push_back(len[15:8]);
    buffer_q.push_back(len[7:0]);
    if (payload > 0) buffer_q.push_back(msg);
    for (int i = 1; i < payload; i++) buffer_q.push_back(8'($urandom));
  endtask

  task automatic send_buffer(input int keep, input bit close);
    int n;
    n = (keep > 0 && keep < buffer_q.size()) ? keep : buffer_q.size();
    for (int i = 0; i < n; i++) send_word(buffer_q[i], close && (i == n - 1));
    buffer_q.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (record_codes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 5))
      0: return ChangeCipherType;
      1: return AlertType;
      2: return HandshakeType;
      3: return HandshakeType;
      4: return tlsrse_pkg::AppDataType;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 20) return 16'd1;
    if (r < 85) return 16'($urandom_range(2, 10));
    if (r < 95) return 16'($urandom_range(11, 300));
    return 16'($urandom);
  endfunction

  // Receiver: random stalls, or one long hold when a test asks for it.
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_hold = LongHold;
    end
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_idle_on) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_stalled = ($urandom_range(0, 2) == 0);
        rx_run = rx_stalled ? idle_len() : $urandom_range(1, 12);
      end
      rx_run = rx_run - 1;
      out_stall_i <= rx_stalled;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (record_codes_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual code %h number %h",
                 $time, out_word_o.state_code, out_word_o.record_number);
      end else begin
        want_word = record_codes_q.pop_front();
        if (out_word_o.state_code !== want_word.state_code) begin
          errors++;
          $display("%0t: state_code expected %h actual %h", $time,
                   want_word.state_code, out_word_o.state_code);
        end
        if (out_word_o.record_number !== want_word.record_number) begin
          errors++;
          $display("%0t: record_number expected %h actual %h", $time,
                   want_word.record_number, out_word_o.record_number);
        end
      end
    end
  end

  task automatic test_directed_records();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // A one-byte record chains into an application data record of length zero.
    add_record(HandshakeType, 16'd1, 8'h02, 1);
    add_record(tlsrse_pkg::AppDataType, 16'd0, 8'hAB, 3);
    send_buffer(0, 1'b1);
    // A normal record is skipped, then the buffer ends inside the next header.
    add_record(8'hFF, 16'd3, 8'h00, 3);
    add_record(ChangeCipherType, 16'd1, 8'h01, 1);
    send_buffer(10, 1'b1);
    // The largest length, cut short by the end of the buffer.
    add_record(8'h00, 16'hFFFF, 8'hFF, 3);
    send_buffer(0, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold_req = 1'b1;
    repeat (8) add_record(pick_type(), 16'd1, 8'($urandom), 1);
    send_buffer(0, 1'b0);
    send_word(8'($urandom), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_records();
    int          stop_at;
    int          nrec;
    int          payload;
    int          keep;
    logic [15:0] len;
    stop_at = words_sent + RandomWords;
    while (words_sent < stop_at) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) buffer_q.push_back(8'($urandom));
        send_buffer(0, 1'b1);
      end else begin
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec; r++) begin
          len = pick_len();
          if (len == 16'd0) payload = $urandom_range(1, 4);
          else if (len > 16'd300) payload = $urandom_range(1, 8);
          else payload = len;
          if ($urandom_range(0, 9) == 0) payload = $urandom_range(0, payload + 2);
          add_record(pick_type(), len, 8'($urandom), payload);
        end
        keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, buffer_q.size()) : 0;
        send_buffer(keep, 1'b1);
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    words_sent = 0;
    errors = 0;
    cycles = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold_req = 1'b0;
    rx_hold = 0;
    rx_run = 0;
    rx_stalled = 1'b0;
    clear_parser();
    rec_count = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_records();
    test_output_backpressure();
    test_random_records();

    if (record_codes_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected words never arrived", $time, record_codes_q.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tlsrse_pkg.sv
hw/rtl/tlsrse_parser.sv
hw/rtl/tlsrse_out_reg.sv
hw/rtl/tls_record_state_extractor.sv
tb/tb_top.sv
